FILE: rtl/kss_pkg.sv
// ----------------------------------------------------------------------------
// kss_pkg
// Shared types and codes for the k-sorted stream sorter and its sorting cells.
// ----------------------------------------------------------------------------
package kss_pkg;

  // width of one stream value and of the displacement register
  localparam int unsigned SampleWidth = 32;
  localparam int unsigned WindowKWidth = 4;

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic [WindowKWidth-1:0] window_k_t;

  // operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT
  } cell_op_t;

  // control group sent from the sequencer to the chain
  typedef struct packed {
    cell_op_t op;
    sample_t  ins_value;
  } cell_ctrl_t;

endpackage

FILE: rtl/kss_cell.sv
// ----------------------------------------------------------------------------
// kss_cell
// One cell of the sorted chain: holds one value, makes room for an inserted
// value by taking its left neighbor's value, or takes its right neighbor's
// value when the head of the chain is removed.
// ----------------------------------------------------------------------------
module kss_cell (
  input  logic                clk,
  input  kss_pkg::cell_ctrl_t ctrl,
  input  logic                valid,
  input  logic                left_gt,
  input  kss_pkg::sample_t    left_value,
  input  kss_pkg::sample_t    right_value,
  output logic                gt,
  output kss_pkg::sample_t    value
);
  import kss_pkg::*;

  sample_t value_next;

  // an empty cell counts as larger than any value
  assign gt = !valid || (value > ctrl.ins_value);

  // next value of the cell
  always_comb begin
    value_next = value;
    case (ctrl.op)
      OP_INSERT: begin
        if (left_gt) begin
          value_next = left_value;
        end else if (gt) begin
          value_next = ctrl.ins_value;
        end
      end
      OP_SHIFT: value_next = right_value;
      default:  value_next = value;
    endcase
  end

  // value register
  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

FILE: rtl/k_sorted_stream_sorter_core.sv
// ----------------------------------------------------------------------------
// k_sorted_stream_sorter_core
// An input is taken in ST_IDLE, then passes ST_POP if the window is full
// (release step) and ST_INSERT (insert step in the cell chain); no new input
// is taken until ST_IDLE again. A released value is registered once the output
// slot is free and is valid on the output from then on; a stalled output
// lengthens the release step. The drain gives one result per cycle while the
// output is not stalled. Reset clears occupancy, window_k and output valid.
// ----------------------------------------------------------------------------
module k_sorted_stream_sorter_core #(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  kss_pkg::window_k_t   cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  kss_pkg::sample_t     sample_value,
  input  logic                 is_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output kss_pkg::sample_t     sorted_value,
  output logic                 last_out
);
  import kss_pkg::*;

  localparam int unsigned OccWidth = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned CapWidth = (OccWidth > WindowKWidth + 1) ?
                                     OccWidth : WindowKWidth + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_INSERT,
    ST_DRAIN
  } state_t;

  state_t               state;
  window_k_t            window_k;
  logic [OccWidth-1:0]  occ;
  sample_t              item_value;
  logic                 item_last;

  logic [CapWidth-1:0]  cap_k;
  logic [CapWidth-1:0]  cap;
  logic                 full;
  logic                 out_free;
  logic                 pop;
  cell_ctrl_t           ctrl;

  sample_t              cell_value [WINDOW_DEPTH];
  logic                 cell_gt    [WINDOW_DEPTH];

  // window capacity and fullness
  assign cap_k = CapWidth'(window_k) + CapWidth'(1);
  assign cap   = (cap_k > CapWidth'(WINDOW_DEPTH)) ? CapWidth'(WINDOW_DEPTH) : cap_k;
  assign full  = (occ != '0) && (CapWidth'(occ) >= cap);

  // output slot handling
  assign out_free = !out_valid || !out_stall;
  assign pop      = ((state == ST_POP) || (state == ST_DRAIN)) && out_free;
  assign in_stall = (state != ST_IDLE);

  // chain command
  always_comb begin
    ctrl.ins_value = item_value;
    if (pop) begin
      ctrl.op = OP_SHIFT;
    end else if (state == ST_INSERT) begin
      ctrl.op = OP_INSERT;
    end else begin
      ctrl.op = OP_HOLD;
    end
  end

  // sorted chain, smallest value at cell 0
  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    logic    cell_valid;
    logic    left_gt;
    sample_t left_value;
    sample_t right_value;

    assign cell_valid = (OccWidth'(i) < occ);

    if (i == 0) begin : g_head
      assign left_gt    = 1'b0;
      assign left_value = cell_value[i];
    end else begin : g_body
      assign left_gt    = cell_gt[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == WINDOW_DEPTH - 1) begin : g_tail
      assign right_value = cell_value[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    kss_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .valid       (cell_valid),
      .left_gt     (left_gt),
      .left_value  (left_value),
      .right_value (right_value),
      .gt          (cell_gt[i]),
      .value       (cell_value[i])
    );
  end

  // sequencer, occupancy and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      window_k  <= '0;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_k <= cfg_wr_data;
      end
      if (pop) begin
        out_valid    <= 1'b1;
        sorted_value <= cell_value[0];
        last_out     <= (state == ST_DRAIN) && (occ == OccWidth'(1));
        occ          <= occ - OccWidth'(1);
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            item_value <= sample_value;
            item_last  <= is_last;
            state      <= full ? ST_POP : ST_INSERT;
          end
        end
        ST_POP: begin
          if (out_free) begin
            state <= ST_INSERT;
          end
        end
        ST_INSERT: begin
          occ   <= occ + OccWidth'(1);
          state <= item_last ? ST_DRAIN : ST_IDLE;
        end
        ST_DRAIN: begin
          if (out_free && (occ == OccWidth'(1))) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // occupancy never exceeds the chain length
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OccWidth'(WINDOW_DEPTH))
    else $error("occupancy above chain length");

  // a release always takes a held value
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (occ != '0))
    else $error("release from empty chain");

  // a release never overwrites a result still waiting
  a_pop_slot: assert property (@(posedge clk) disable iff (rst)
    pop |-> (!out_valid || !out_stall))
    else $error("result overwritten");

  // head of the chain holds the smallest value
  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_IDLE) && (occ >= OccWidth'(2))) |-> (cell_value[0] <= cell_value[1]))
    else $error("chain head out of order");

endmodule

FILE: verif/tb_k_sorted_stream_sorter_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_k_sorted_stream_sorter_core
// Streams nearly sorted and random signed values through the sorter under
// several window sizes, with random gaps and stalls on both channels and one
// long output hold-off. A scoreboard keeps its own copy of the window and
// checks every released value and end-of-stream mark in order.
// ----------------------------------------------------------------------------

// window copy and queue of released values still owed by the block
class sort_scoreboard;
  localparam int unsigned Slots = 16;

  typedef struct packed {
    kss_pkg::sample_t value;
    logic             last;
  } sorted_result_t;

  kss_pkg::sample_t    window_vals[Slots];
  int unsigned         held;
  kss_pkg::window_k_t  window_k;
  sorted_result_t      expected_q[$];
  int unsigned         errors;

  function new();
    held = 0;
    window_k = '0;
    errors = 0;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  // remove the smallest held value, last slot moves into the hole
  function kss_pkg::sample_t pull_min();
    int unsigned best;
    kss_pkg::sample_t v;
    best = 0;
    for (int unsigned i = 1; i < held; i++) begin
      if (window_vals[i] < window_vals[best]) best = i;
    end
    v = window_vals[best];
    held--;
    window_vals[best] = window_vals[held];
    return v;
  endfunction

  // accepted input transaction: release when full, store, drain on last
  function void note_input(kss_pkg::sample_t v, logic last);
    int unsigned cap;
    sorted_result_t r;
    cap = int'(window_k) + 1;
    if (cap > Slots) cap = Slots;
    if (held != 0 && held >= cap) begin
      r.value = pull_min();
      r.last = 1'b0;
      expected_q.push_back(r);
    end
    if (held < Slots) begin
      window_vals[held] = v;
      held++;
    end
    if (last) begin
      while (held != 0) begin
        r.value = pull_min();
        r.last = (held == 0);
        expected_q.push_back(r);
      end
    end
  endfunction

  // accepted output transaction against the oldest expectation
  function void check_result(kss_pkg::sample_t v, logic last);
    sorted_result_t want;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result: expected none, actual value %0d last %0b",
               $time, v, last);
      return;
    end
    want = expected_q.pop_front();
    if (v !== want.value) begin
      errors++;
      $display("%0t: sorted_value mismatch: expected %0d actual %0d",
               $time, want.value, v);
    end
    if (last !== want.last) begin
      errors++;
      $display("%0t: last_out mismatch: expected %0b actual %0b",
               $time, want.last, last);
    end
  endfunction
endclass

module tb_k_sorted_stream_sorter_core;
  import kss_pkg::*;

  localparam int unsigned NumItems = 410;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned WatchdogLimit = 2000;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  window_k_t   cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  sample_t     sample_value;
  logic        is_last;
  logic        out_valid;
  logic        out_stall;
  sample_t     sorted_value;
  logic        last_out;

  sort_scoreboard sorter = new();
  int unsigned    items_sent;
  int unsigned    rx_wait;
  int unsigned    idle_cycles;
  bit             gapless;
  bit             hold_req;

  k_sorted_stream_sorter_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_value (sample_value),
    .is_last      (is_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_value (sorted_value),
    .last_out     (last_out)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // output monitor, draws the next receive stall after each transaction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sorter.check_result(sorted_value, last_out);
      rx_wait = gapless ? 0 : $urandom_range(0, 14);
    end
  end

  // receiver stall, with one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
        out_stall = 1'b0;
      end else begin
        out_stall = (rx_wait != 0);
        if (rx_wait != 0) rx_wait--;
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // values weighted toward the extremes of the field
  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0: return sample_t'(32'h8000_0000);
      1: return sample_t'(32'h7fff_ffff);
      2: return '0;
      3: return '1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // one input transaction after a random gap
  task automatic send_sample(input sample_t v, input logic last);
    int unsigned gap;
    gap = gapless ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    sample_value = v;
    is_last = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sorter.note_input(v, last);
    items_sent++;
    @(negedge clk);
  endtask

  // ascending run with local swaps no further than spread
  task automatic send_stream(input int unsigned len, input int unsigned spread,
                             input bit closed);
    sample_t vals[$];
    sample_t base;
    sample_t tmp;
    int unsigned j;
    base = rand_sample();
    for (int unsigned i = 0; i < len; i++) begin
      vals.push_back(base);
      base = base + sample_t'($urandom_range(0, 5000));
    end
    for (int unsigned i = 0; i < len; i++) begin
      j = i + $urandom_range(0, spread);
      if (j < len) begin
        tmp = vals[i];
        vals[i] = vals[j];
        vals[j] = tmp;
      end
    end
    for (int unsigned i = 0; i < len; i++) begin
      send_sample(vals[i], closed && (i == len - 1));
    end
  endtask

  // wait for all owed results, let the block settle, then write window_k
  task automatic set_window_k(input window_k_t k);
    in_valid = 1'b0;
    while (sorter.pending() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = k;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sorter.window_k = k;
  endtask

  initial begin
    window_k_t k;
    int unsigned phase;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    sample_value = '0;
    is_last = 1'b0;
    items_sent = 0;
    rx_wait = 0;
    idle_cycles = 0;
    gapless = 1'b0;
    hold_req = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // single-slot window with the field extremes
    set_window_k(4'd0);
    send_sample(sample_t'(32'h8000_0000), 1'b0);
    send_sample(sample_t'(32'h7fff_ffff), 1'b0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b1);

    // largest window, stream ends before it fills, equal values
    set_window_k(4'd15);
    send_sample(sample_t'(5), 1'b0);
    send_sample(sample_t'(-5), 1'b0);
    send_sample(sample_t'(5), 1'b0);
    send_sample(sample_t'(5), 1'b1);

    // stream of one item
    send_sample(sample_t'(42), 1'b1);

    // window shrunk while it still holds values
    set_window_k(4'd7);
    for (int i = 0; i < 6; i++) send_sample(rand_sample(), 1'b0);
    set_window_k(4'd2);
    for (int i = 0; i < 5; i++) send_sample(rand_sample(), i == 4);

    // reversed run in a mid-size window
    set_window_k(4'd4);
    for (int i = 0; i < 5; i++) send_sample(sample_t'(100 - i * 7), i == 4);

    // random phases
    phase = 0;
    while (items_sent < NumItems) begin
      case ($urandom_range(0, 5))
        0: k = 4'd0;
        1: k = 4'd15;
        default: k = window_k_t'($urandom_range(0, 15));
      endcase
      if (phase == 3) k = 4'd15;
      set_window_k(k);
      gapless = ($urandom_range(0, 3) == 0);
      if (phase == 3) begin
        // receiver holds off while a long stream fills the block
        hold_req = 1'b1;
        send_stream(40, 15, 1'b1);
      end else begin
        for (int s = $urandom_range(1, 3); s > 0; s--) begin
          if ($urandom_range(0, 4) == 0) begin
            for (int i = $urandom_range(1, 20); i > 0; i--) begin
              send_sample(rand_sample(), $urandom_range(0, 7) == 0);
            end
          end else if ($urandom_range(0, 5) == 0) begin
            send_stream($urandom_range(17, 40), k, 1'b1);
          end else begin
            send_stream($urandom_range(1, 24), k, 1'b1);
          end
        end
      end
      phase++;
    end
    gapless = 1'b0;

    // close the last stream so the window drains
    send_stream(3, 1, 1'b1);
    in_valid = 1'b0;
    while (sorter.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sorter.errors == 0 && sorter.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
